// ----- sv/m4inv_pkg.sv -----
// Shared types, constants and helper functions for the 4x4 adjugate inverse block.
package m4inv_pkg;

	localparam int ElemWidth = 32;
	localparam int FracBits  = 16;
	localparam int CofWidth  = 3 * ElemWidth + 2;
	localparam int DetWidth  = 4 * ElemWidth + 4;
	localparam int NumWidth  = CofWidth + 2 * FracBits;
	localparam int QuoWidth  = NumWidth;
	localparam int QCntWidth = $clog2(QuoWidth + 1);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_COF,
		ST_DET,
		ST_DIV_START,
		ST_DIV_RUN,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_COF,
		OP_DET,
		OP_DIV
	} op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       store_en;
		logic [3:0] store_idx;
		op_t        op;
		logic [3:0] idx;
		logic       emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_done;
		logic det_zero;
	} status_t;

	// Returns the k-th of the three indices in 0..3 that differ from skip.
	function automatic logic [1:0] keep_idx(input logic [1:0] skip, input logic [1:0] k);
		logic [2:0] v;
		v = {1'b0, k};
		if (v >= {1'b0, skip}) v = v + 3'd1;
		return v[1:0];
	endfunction

endpackage

// ----- sv/m4inv_if.sv -----
// Valid/ready stream interfaces for input elements and result elements.
interface m4inv_in_if;
	logic                 valid;
	logic                 ready;
	logic signed [31:0]   element;
	modport source (output valid, output element, input ready);
	modport sink   (input valid, input element, output ready);
endinterface

interface m4inv_out_if;
	logic                 valid;
	logic                 ready;
	logic signed [31:0]   inv_element;
	logic [3:0]           index;
	logic                 singular;
	logic                 saturated;
	logic                 last;
	modport source (output valid, output inv_element, output index, output singular,
		output saturated, output last, input ready);
	modport sink   (input valid, input inv_element, input index, input singular,
		input saturated, input last, output ready);
endinterface

// ----- sv/m4inv_ctrl.sv -----
// Controller state machine sequencing load, cofactors, determinant, divisions and output.
module m4inv_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  m4inv_pkg::status_t  status,
	output m4inv_pkg::cmd_t     cmd
);
	import m4inv_pkg::*;

	state_t     state_q, state_d;
	logic [3:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		case (state_q)
			ST_LOAD: begin
				if (in_valid) begin
					cnt_d = cnt_q + 4'd1;
					if (cnt_q == 4'd15) state_d = ST_COF;
				end
			end
			ST_COF: begin
				cnt_d = cnt_q + 4'd1;
				if (cnt_q == 4'd15) state_d = ST_DET;
			end
			ST_DET: begin
				cnt_d = cnt_q + 4'd1;
				if (cnt_q == 4'd11) begin
					cnt_d   = '0;
					state_d = ST_DIV_START;
				end
			end
			ST_DIV_START: begin
				if (status.det_zero) state_d = ST_EMIT;
				else state_d = ST_DIV_RUN;
			end
			ST_DIV_RUN: begin
				if (status.div_done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_ready) begin
					cnt_d = cnt_q + 4'd1;
					if (cnt_q == 4'd15) state_d = ST_LOAD;
					else state_d = ST_DIV_START;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		out_valid     = 1'b0;
		cmd.store_en  = 1'b0;
		cmd.store_idx = cnt_q;
		cmd.op        = OP_NONE;
		cmd.idx       = cnt_q;
		cmd.emit      = 1'b0;
		case (state_q)
			ST_LOAD: begin
				in_ready     = 1'b1;
				cmd.store_en = in_valid;
			end
			ST_COF: cmd.op = OP_COF;
			ST_DET: cmd.op = OP_DET;
			ST_DIV_START: cmd.op = OP_DIV;
			ST_EMIT: begin
				out_valid = 1'b1;
				cmd.emit  = out_ready;
			end
			default: ;
		endcase
	end
endmodule

// ----- sv/m4inv_dp.sv -----
// Datapath: element store, cofactor and determinant unit, restoring divider, output stage.
module m4inv_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [31:0] element,
	input  m4inv_pkg::cmd_t    cmd,
	output m4inv_pkg::status_t status,
	output logic signed [31:0] inv_element,
	output logic [3:0]         index,
	output logic               singular,
	output logic               saturated,
	output logic               last
);
	import m4inv_pkg::*;

	logic signed [ElemWidth-1:0] mat_q [16];
	logic signed [CofWidth-1:0]  cof_q [16];
	logic signed [DetWidth-1:0]  det_q;

	// Cofactor pipeline: minor elements and 2x2 products, then each first-row term as
	// two partial products over ElemWidth-bit slices, their recombination, and the
	// 3x3 sum at the write.
	logic signed [ElemWidth-1:0] m [9];
	logic [1:0] ri, ci;
	logic signed [2*ElemWidth-1:0]   p_a_s1, p_b_s1, p_c_s1, p_d_s1, p_e_s1, p_f_s1;
	logic signed [ElemWidth-1:0]     e_a_s1, e_b_s1, e_c_s1;
	logic [3:0]                      idx_s1, idx_s2, idx_s3;
	logic                            vld_s1, vld_s2, vld_s3;
	logic signed [2*ElemWidth:0]     lo_a_s2, lo_b_s2, lo_c_s2;
	logic signed [2*ElemWidth:0]     hi_a_s2, hi_b_s2, hi_c_s2;
	logic signed [CofWidth-1:0]      t_a_s3, t_b_s3, t_c_s3;
	logic signed [2*ElemWidth:0]     d1, d2, d3;
	logic signed [CofWidth-1:0]      cof_new;

	assign ri = cmd.idx[3:2];
	assign ci = cmd.idx[1:0];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				m[r*3+c] = mat_q[{keep_idx(ri, r[1:0]), keep_idx(ci, c[1:0])}];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= (cmd.op == OP_COF);
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	assign d1 = (2*ElemWidth+1)'(p_a_s1) - (2*ElemWidth+1)'(p_b_s1);
	assign d2 = (2*ElemWidth+1)'(p_c_s1) - (2*ElemWidth+1)'(p_d_s1);
	assign d3 = (2*ElemWidth+1)'(p_e_s1) - (2*ElemWidth+1)'(p_f_s1);

	always_ff @(posedge clk) begin
		if (cmd.store_en) mat_q[cmd.store_idx] <= element;
		p_a_s1 <= m[4] * m[8];
		p_b_s1 <= m[5] * m[7];
		p_c_s1 <= m[3] * m[8];
		p_d_s1 <= m[5] * m[6];
		p_e_s1 <= m[3] * m[7];
		p_f_s1 <= m[4] * m[6];
		e_a_s1 <= m[0];
		e_b_s1 <= m[1];
		e_c_s1 <= m[2];
		idx_s1 <= cmd.idx;
		lo_a_s2 <= e_a_s1 * $signed({1'b0, d1[ElemWidth-1:0]});
		hi_a_s2 <= e_a_s1 * $signed(d1[2*ElemWidth:ElemWidth]);
		lo_b_s2 <= e_b_s1 * $signed({1'b0, d2[ElemWidth-1:0]});
		hi_b_s2 <= e_b_s1 * $signed(d2[2*ElemWidth:ElemWidth]);
		lo_c_s2 <= e_c_s1 * $signed({1'b0, d3[ElemWidth-1:0]});
		hi_c_s2 <= e_c_s1 * $signed(d3[2*ElemWidth:ElemWidth]);
		idx_s2 <= idx_s1;
		t_a_s3 <= (CofWidth'(hi_a_s2) <<< ElemWidth) + CofWidth'(lo_a_s2);
		t_b_s3 <= (CofWidth'(hi_b_s2) <<< ElemWidth) + CofWidth'(lo_b_s2);
		t_c_s3 <= (CofWidth'(hi_c_s2) <<< ElemWidth) + CofWidth'(lo_c_s2);
		idx_s3 <= idx_s2;
	end

	assign cof_new = t_a_s3 - t_b_s3 + t_c_s3;

	// Determinant accumulates one first-row element times one slice of its cofactor
	// per cycle: idx[1:0] picks the column, idx[3:2] the slice.
	logic signed [CofWidth-1:0]      det_cof;
	logic signed [ElemWidth+1:0]     det_limb;
	logic signed [2*ElemWidth+1:0]   det_prod;
	logic signed [DetWidth-1:0]      det_term;

	always_comb begin
		det_cof = cof_q[{2'd0, cmd.idx[1:0]}];
		case (cmd.idx[3:2])
			2'd0: det_limb = {2'b00, det_cof[ElemWidth-1:0]};
			2'd1: det_limb = {2'b00, det_cof[2*ElemWidth-1:ElemWidth]};
			default: det_limb = det_cof[CofWidth-1:2*ElemWidth];
		endcase
		det_prod = mat_q[{2'd0, cmd.idx[1:0]}] * det_limb;
		case (cmd.idx[3:2])
			2'd0: det_term = DetWidth'(det_prod);
			2'd1: det_term = DetWidth'(det_prod) <<< ElemWidth;
			default: det_term = DetWidth'(det_prod) <<< (2 * ElemWidth);
		endcase
	end

	always_ff @(posedge clk) begin
		if (vld_s3) cof_q[idx_s3] <= (idx_s3[0] ^ idx_s3[2]) ? -cof_new : cof_new;
		if (cmd.op == OP_DET) begin
			if (cmd.idx == 4'd0) det_q <= det_term;
			else det_q <= det_q + det_term;
		end
	end

	// Restoring divider, one quotient bit per cycle.
	logic [DetWidth-1:0]  dmag_q;
	logic                 dneg_q, nneg_q, busy_q;
	logic [NumWidth-1:0]  num_q;
	logic [DetWidth:0]    rem_q;
	logic [QCntWidth-1:0] bit_q;
	logic [3:0]           out_idx_q;
	logic signed [CofWidth-1:0] numsrc;
	logic [DetWidth:0]    rem_sh, rem_sub;

	assign numsrc  = cof_q[{out_idx_q[1:0], out_idx_q[3:2]}];
	assign rem_sh  = {rem_q[DetWidth-1:0], num_q[NumWidth-1]};
	assign rem_sub = rem_sh - {1'b0, dmag_q};
	assign status.det_zero = (det_q == '0);
	assign status.div_done = busy_q && (bit_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			out_idx_q <= '0;
		end else begin
			if (cmd.op == OP_DIV && !status.det_zero) busy_q <= 1'b1;
			else if (status.div_done) busy_q <= 1'b0;
			if (cmd.emit) out_idx_q <= out_idx_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_DIV) begin
			dneg_q <= det_q[DetWidth-1];
			dmag_q <= det_q[DetWidth-1] ? -det_q : det_q;
			nneg_q <= numsrc[CofWidth-1];
			num_q  <= {(numsrc[CofWidth-1] ? -numsrc : numsrc), {(2*FracBits){1'b0}}};
			rem_q  <= '0;
			bit_q  <= QCntWidth'(QuoWidth);
		end else if (busy_q && bit_q != '0) begin
			if (!rem_sub[DetWidth]) begin
				rem_q <= rem_sub;
				num_q <= {num_q[NumWidth-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				num_q <= {num_q[NumWidth-2:0], 1'b0};
			end
			bit_q <= bit_q - 1'b1;
		end
	end

	// After the sweep num_q holds the unsigned quotient.
	logic qneg, over;
	logic [ElemWidth-1:0] mag;
	always_comb begin
		qneg = (nneg_q != dneg_q) && (num_q != '0);
		over = (num_q[NumWidth-1:ElemWidth-1] != '0);
		mag  = num_q[ElemWidth-1:0];
		if (qneg && num_q == NumWidth'({1'b1, {(ElemWidth-1){1'b0}}})) over = 1'b0;
		if (over) mag = qneg ? {1'b1, {(ElemWidth-1){1'b0}}} : {1'b0, {(ElemWidth-1){1'b1}}};
		singular    = status.det_zero;
		saturated   = !singular && over;
		inv_element = singular ? mat_q[out_idx_q] : (qneg ? -mag : mag);
		index       = out_idx_q;
		last        = (out_idx_q == 4'd15);
	end
endmodule

// ----- sv/matrix4_inverse_adjugate.sv -----
// Top level of the 4x4 matrix inverse by adjugate and exact division.
// Input channel in_word carries one signed Q16.16 element per word, in
// row-major order; sixteen words make one matrix and are taken one per cycle.
// After the sixteenth word the block stops accepting and issues the sixteen
// cofactors into a multiplier pipeline, one per cycle. It then accumulates
// the determinant along the first row, one slice of a cofactor per cycle
// (two 32-bit slices and a 34-bit top slice). For each result the block
// passes a start state, runs a restoring divider that yields one quotient
// bit per cycle, and then enters an output state; the divider loop dominates
// the time per matrix. A singular matrix skips the divider for every result.
// Output channel out_word gives sixteen words per matrix: the element of the
// inverse, its index, the singular and saturated flags and last on the
// sixteenth. A zero determinant returns the stored elements with singular set.
// While the receiver stalls the current result word holds steady and the
// block waits; nothing is lost. Reset clears the sequencer and load count;
// the element store needs no reset. No new matrix is taken while results of
// the previous one are still pending.
module matrix4_inverse_adjugate (
	input  logic clk,
	input  logic arst_n,
	m4inv_in_if.sink    in_word,
	m4inv_out_if.source out_word
);
	import m4inv_pkg::*;

	cmd_t    cmd;
	status_t status;

	m4inv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_word.valid),
		.in_ready  (in_word.ready),
		.out_valid (out_word.valid),
		.out_ready (out_word.ready),
		.status    (status),
		.cmd       (cmd)
	);

	m4inv_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.element     (in_word.element),
		.cmd         (cmd),
		.status      (status),
		.inv_element (out_word.inv_element),
		.index       (out_word.index),
		.singular    (out_word.singular),
		.saturated   (out_word.saturated),
		.last        (out_word.last)
	);
endmodule

// ----- sv/m4inv_checker.sv -----
// Port-level checker for the matrix inverse block, bound to the top level.
module m4inv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  index,
	input logic        singular,
	input logic        saturated,
	input logic        last
);
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input taken while results pending");
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (index == 4'd15))) else $error("last flag mismatch");
	a_sing_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> !saturated) else $error("singular with saturated");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(index))
		else $error("stalled result changed");
endmodule

bind matrix4_inverse_adjugate m4inv_checker u_m4inv_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_word.ready),
	.out_valid (out_word.valid),
	.out_ready (out_word.ready),
	.index     (out_word.index),
	.singular  (out_word.singular),
	.saturated (out_word.saturated),
	.last      (out_word.last)
);
